FILE: rtl/fpd_pkg.sv
package fpd_pkg;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_INIT  = 10'b00_0000_0010,
        ST_CMP   = 10'b00_0000_0100,
        ST_SUBW  = 10'b00_0000_1000,
        ST_DIV   = 10'b00_0001_0000,
        ST_SNAP  = 10'b00_0010_0000,
        ST_SKIP  = 10'b00_0100_0000,
        ST_DWAIT = 10'b00_1000_0000,
        ST_EMIT  = 10'b01_0000_0000,
        ST_ADV   = 10'b10_0000_0000
    } t_state;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_DROP     = 1'b1;

    localparam logic ACT_PULL  = 1'b0;
    localparam logic ACT_RESET = 1'b1;

    localparam int IV_BITS   = 32;
    localparam int SEQ_BITS  = 32;
    localparam int WAIT_BITS = 32;
    localparam int NOW_BITS  = 48;

endpackage

FILE: rtl/fpd_in_if.sv
interface fpd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [fpd_pkg::NOW_BITS-1:0]  now_us;

    modport source (output valid, output action, output now_us, input ready);
    modport sink   (input valid, input action, input now_us, output ready);
endinterface

FILE: rtl/fpd_out_if.sv
interface fpd_out_if;
    logic                          valid;
    logic                          ready;
    logic [fpd_pkg::WAIT_BITS-1:0] wait_us;
    logic [fpd_pkg::NOW_BITS-1:0]  emit_time_us;
    logic [fpd_pkg::SEQ_BITS-1:0]  frame_seq;

    modport source (output valid, output wait_us, output emit_time_us, output frame_seq,
                    input ready);
    modport sink   (input valid, input wait_us, input emit_time_us, input frame_seq,
                    output ready);
endinterface

FILE: rtl/frame_pacer_with_drop.sv
// channel   dir  payload                              transfer when
// i_in_ch   in   action, now_us                       valid && ready
// o_out_ch  out  wait_us, emit_time_us, frame_seq     valid && ready
// cfg       in   i_cfg_idx, i_cfg_data                i_cfg_we
//
// reset item: no result; the first pull after a reset item also passes through ST_INIT
// early pull: CMP, SUBW, EMIT, ADV; unpaced late pull: CMP, EMIT, ADV; late pull: CMP, DIV,
// SNAP, EMIT, ADV, with SKIP and DWAIT after SNAP in drop mode; DIV is a restoring divider, one quotient bit a cycle
// result sits in an output register, the next item is taken while it waits
// a full output register holds the sequencer in its last step
// i_rst_n is synchronous and clears state, output valid, config, schedule and sequence
module frame_pacer_with_drop #(
    parameter int TIME_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [fpd_pkg::IV_BITS-1:0]   i_cfg_data,
    fpd_in_if.sink                        i_in_ch,
    fpd_out_if.source                     o_out_ch
);

    localparam int TW = (TIME_BITS + 2 > 64) ? 64 : TIME_BITS + 2;
    localparam int UW = TW + 1;
    localparam int CW = $clog2(TIME_BITS);
    localparam logic [TW-1:0]        NEXT_MAX  = '1;
    localparam logic [TIME_BITS-1:0] TIME_MASK = '1;

    fpd_pkg::t_state                 r_state, n_state;
    logic                            r_started, n_started;
    logic [TW-1:0]                   r_tick, n_tick;
    logic [fpd_pkg::SEQ_BITS-1:0]    r_seq, n_seq;
    logic [fpd_pkg::IV_BITS-1:0]     r_iv;
    logic                            r_drop;
    logic [TIME_BITS-1:0]            r_now, n_now;
    logic [TIME_BITS-1:0]            r_quo, n_quo;
    logic [fpd_pkg::IV_BITS-1:0]     r_rem, n_rem;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [TW-1:0]                   r_wait, n_wait;
    logic [TIME_BITS-1:0]            r_emit, n_emit;
    logic                            r_out_valid, n_out_valid;
    logic [fpd_pkg::WAIT_BITS-1:0]   r_out_wait, n_out_wait;
    logic [fpd_pkg::NOW_BITS-1:0]    r_out_emit, n_out_emit;
    logic [fpd_pkg::SEQ_BITS-1:0]    r_out_seq, n_out_seq;

    fpd_pkg::t_alu_op                alu_op;
    logic [UW-1:0]                   alu_a, alu_b, alu_s;
    logic [fpd_pkg::IV_BITS:0]       div_shift;
    logic [fpd_pkg::WAIT_BITS-1:0]   wait_clamp;
    logic [TW-1:0]                   tick_sat;
    logic                            in_xfer, out_free;

    fpd_addsub #(.W(UW)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_s  (alu_s)
    );

    assign in_xfer    = i_in_ch.valid && i_in_ch.ready;
    assign out_free   = !r_out_valid || o_out_ch.ready;
    assign div_shift  = {r_rem, r_quo[TIME_BITS-1]};
    assign wait_clamp = (|r_wait[TW-1:fpd_pkg::WAIT_BITS]) ? '1
                                                           : r_wait[fpd_pkg::WAIT_BITS-1:0];
    assign tick_sat   = alu_s[UW-1] ? NEXT_MAX : alu_s[TW-1:0];

    assign i_in_ch.ready         = (r_state == fpd_pkg::ST_IDLE);
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.wait_us      = r_out_wait;
    assign o_out_ch.emit_time_us = r_out_emit;
    assign o_out_ch.frame_seq    = r_out_seq;

    // shared adder operand select
    always_comb begin
        alu_op = fpd_pkg::ALU_ADD;
        alu_a  = UW'(r_tick);
        alu_b  = UW'(r_iv);
        unique case (r_state)
            fpd_pkg::ST_INIT: begin
                alu_a = UW'(r_now);
            end
            fpd_pkg::ST_CMP: begin
                alu_op = fpd_pkg::ALU_SUB;
                alu_a  = UW'(r_now);
                alu_b  = UW'(r_tick);
            end
            fpd_pkg::ST_SUBW, fpd_pkg::ST_DWAIT: begin
                alu_op = fpd_pkg::ALU_SUB;
                alu_b  = UW'(r_now);
            end
            fpd_pkg::ST_DIV: begin
                alu_op = fpd_pkg::ALU_SUB;
                alu_a  = UW'(div_shift);
            end
            fpd_pkg::ST_SNAP: begin
                alu_op = fpd_pkg::ALU_SUB;
                alu_a  = UW'(r_now);
                alu_b  = UW'(r_rem);
            end
            fpd_pkg::ST_EMIT: begin
                alu_a = UW'(r_now);
                alu_b = UW'(wait_clamp);
            end
            default: begin
                alu_op = fpd_pkg::ALU_ADD;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_tick      = r_tick;
        n_seq       = r_seq;
        n_now       = r_now;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_wait      = r_wait;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_wait  = r_out_wait;
        n_out_emit  = r_out_emit;
        n_out_seq   = r_out_seq;
        unique case (r_state)
            fpd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_ch.action == fpd_pkg::ACT_RESET) begin
                        n_started = 1'b0;
                        n_tick    = '0;
                        n_seq     = '0;
                    end else begin
                        n_now   = TIME_BITS'(i_in_ch.now_us);
                        n_state = r_started ? fpd_pkg::ST_CMP : fpd_pkg::ST_INIT;
                    end
                end
            end
            fpd_pkg::ST_INIT: begin
                n_tick    = tick_sat;
                n_started = 1'b1;
                n_state   = fpd_pkg::ST_CMP;
            end
            fpd_pkg::ST_CMP: begin
                if (alu_s[UW-1]) begin
                    n_state = fpd_pkg::ST_SUBW;
                end else if (r_iv == '0) begin
                    n_wait  = '0;
                    n_state = fpd_pkg::ST_EMIT;
                end else begin
                    n_quo   = alu_s[TIME_BITS-1:0];
                    n_rem   = '0;
                    n_cnt   = CW'(TIME_BITS - 1);
                    n_state = fpd_pkg::ST_DIV;
                end
            end
            fpd_pkg::ST_SUBW: begin
                n_wait  = alu_s[TW-1:0];
                n_state = fpd_pkg::ST_EMIT;
            end
            fpd_pkg::ST_DIV: begin
                n_rem = alu_s[UW-1] ? div_shift[fpd_pkg::IV_BITS-1:0]
                                    : alu_s[fpd_pkg::IV_BITS-1:0];
                n_quo = {r_quo[TIME_BITS-2:0], ~alu_s[UW-1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = fpd_pkg::ST_SNAP;
                end
            end
            fpd_pkg::ST_SNAP: begin
                // last boundary at or before now
                n_tick = alu_s[TW-1:0];
                if (r_drop) begin
                    n_state = fpd_pkg::ST_SKIP;
                end else begin
                    n_wait  = '0;
                    n_state = fpd_pkg::ST_EMIT;
                end
            end
            fpd_pkg::ST_SKIP: begin
                n_tick  = tick_sat;
                n_seq   = r_seq + r_quo[fpd_pkg::SEQ_BITS-1:0] + 1'b1;
                n_state = fpd_pkg::ST_DWAIT;
            end
            fpd_pkg::ST_DWAIT: begin
                n_wait  = alu_s[TW-1:0];
                n_state = fpd_pkg::ST_EMIT;
            end
            fpd_pkg::ST_EMIT: begin
                n_emit  = (|alu_s[UW-1:TIME_BITS]) ? TIME_MASK : alu_s[TIME_BITS-1:0];
                n_state = fpd_pkg::ST_ADV;
            end
            fpd_pkg::ST_ADV: begin
                if (out_free) begin
                    n_tick      = tick_sat;
                    n_seq       = r_seq + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_wait  = wait_clamp;
                    n_out_emit  = fpd_pkg::NOW_BITS'(r_emit);
                    n_out_seq   = r_seq;
                    n_state     = fpd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpd_pkg::ST_IDLE;
            r_started   <= 1'b0;
            r_tick      <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_tick      <= n_tick;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_wait     <= n_wait;
        r_emit     <= n_emit;
        r_out_wait <= n_out_wait;
        r_out_emit <= n_out_emit;
        r_out_seq  <= n_out_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv   <= '0;
            r_drop <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpd_pkg::CFG_INTERVAL: r_iv   <= i_cfg_data;
                fpd_pkg::CFG_DROP:     r_drop <= i_cfg_data[0];
                default:               r_drop <= r_drop;
            endcase
        end
    end

endmodule

FILE: rtl/fpd_addsub.sv
module fpd_addsub #(
    parameter int W = 51
) (
    input  fpd_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_s
);

    always_comb begin
        unique case (i_op)
            fpd_pkg::ALU_ADD: o_s = i_a + i_b;
            fpd_pkg::ALU_SUB: o_s = i_a - i_b;
            default:          o_s = i_a + i_b;
        endcase
    end

endmodule

FILE: rtl/fpd_checker.sv
module fpd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_action,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [fpd_pkg::WAIT_BITS-1:0] i_out_wait,
    input logic [fpd_pkg::NOW_BITS-1:0]  i_out_emit,
    input logic [fpd_pkg::SEQ_BITS-1:0]  i_out_seq
);

    // the block is ready again in the cycle after a reset item
    a_reset_item_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action == fpd_pkg::ACT_RESET |=> i_in_ready)
        else $error("fpd: not ready after reset item");

    // a pull keeps the block busy
    a_pull_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action == fpd_pkg::ACT_PULL |=> !i_in_ready)
        else $error("fpd: ready right after a pull");

    // a new result only appears when the block returns to ready
    a_result_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) ##1 i_out_valid |-> i_in_ready)
        else $error("fpd: result loaded while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_wait)
            && $stable(i_out_emit) && $stable(i_out_seq))
        else $error("fpd: stalled result changed");

endmodule

bind frame_pacer_with_drop fpd_checker u_fpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_action (i_in_ch.action),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_wait  (o_out_ch.wait_us),
    .i_out_emit  (o_out_ch.emit_time_us),
    .i_out_seq   (o_out_ch.frame_seq)
);
